### rtl/core/assert_macros.svh
// Assertion macros shared by the voice core RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define TESV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define TESV_ASSERT_NEVER(lbl, cond, msg) \
  `TESV_ASSERT(lbl, !(cond), msg)

`endif

### rtl/core/tesv_pkg.sv
// Package for the tone/envelope voice core: widths, codes, shared types
// and the elaborated sine table. No dependencies.
package tesv_pkg;

  localparam int unsigned PHASE_BITS = 24;
  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned SINE_ABITS = $clog2(SINE_DEPTH);
  localparam int unsigned INDEX_BITS = 20;

  // register field widths
  localparam int unsigned WAVE_W  = 3;
  localparam int unsigned INC_W   = 24;
  localparam int unsigned GLIDE_W = 25;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned VOL_W   = 17;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ENV_FRAC = 16;           // envelope Q0.16
  localparam int unsigned ENV_W    = ENV_FRAC + 1; // holds 1.0
  localparam int unsigned MAG_W    = 17;           // |wave| up to 32768
  localparam int unsigned MUL_A_W  = VOL_W + ENV_W;
  localparam int unsigned MUL_B_W  = MAG_W;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned AMP_SHIFT = 15;          // 32767 = 2^15 - 1
  localparam int unsigned OUT_SHIFT = 47;

  localparam logic [SEED_W-1:0] SEED_DEFAULT = 32'd1337;
  localparam logic [SEED_W-1:0] LFSR_TAPS    = 32'h8020_0003;
  localparam logic [VOL_W-1:0]  VOL_RESET    = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM   = 3'd0,
    CFG_START_INC  = 3'd1,
    CFG_GLIDE      = 3'd2,
    CFG_TOTAL      = 3'd3,
    CFG_ATTACK     = 3'd4,
    CFG_DECAY      = 3'd5,
    CFG_VOLUME     = 3'd6,
    CFG_NOISE_SEED = 3'd7
  } cfg_idx_e;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_NOISE    = 3'd4
  } wave_e;

  // serial envelope divider handshake
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;  // below divisor whenever start is set
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [ENV_FRAC-1:0] quotient;
  } div_resp_t;

  // sine table, worked out at elaboration
  typedef logic signed [MAG_W-1:0] sine_rom_t [SINE_DEPTH];

  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint QS_DIV [6] = '{6, 20, 42, 72, 110, 156};

  function automatic longint quarter_sine(longint r);
    longint x;
    longint term;
    longint sum;
    longint v;
    x = (HALF_PI_Q30 * r) / SINE_DEPTH;
    term = x;
    sum = x;
    for (int k = 0; k < 6; k++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = term / QS_DIV[k];
      if ((k % 2) == 0) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum * 32768 + (64'sd1 <<< 29)) >>> 30;
    if (v > 32768) v = 32768;
    return v;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint m;
    longint quad;
    longint rem;
    longint r;
    longint v;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      m = 4 * k;
      quad = m / SINE_DEPTH;
      rem = m % SINE_DEPTH;
      r = ((quad % 2) == 1) ? (SINE_DEPTH - rem) : rem;
      v = quarter_sine(r);
      if (quad >= 2) v = -v;
      rom[k] = MAG_W'(v);
    end
    return rom;
  endfunction

endpackage

### rtl/core/tesv_if.sv
// Valid/ready stream interfaces for the voice core: sample tick in, PCM out.
// Stand-alone; no package needed.
interface tesv_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink   (input valid, input start_req, output ready);
endinterface

interface tesv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic               active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

### rtl/core/tone_envelope_synth_voice_core.sv
// Top level of the one-voice tone generator with attack/decay envelope.
// Uses tesv_pkg, tesv_if (stream interfaces), tesv_env_div, assert_macros.svh.
//
//  channel  dir  beat payload               accepted when
//  -------  ---  -------------------------  -----------------------
//  in_i     in   start_req                  in_i.valid & in_i.ready
//  out_o    out  sample, last, active       out_o.valid & out_o.ready
//  cfg      in   cfg_idx_i, cfg_data_i      cfg_we_i
//
// A sounding beat passes S_PREP, S_WAVE, S_MUL1, S_MUL2, S_SCALE and S_DONE;
// on an envelope ramp it also waits in S_DIV for the serial divider, which
// finds one quotient bit at a time. An idle voice goes from S_PREP to S_DONE.
// Reset is asynchronous, active low; no clearing pass is needed.
// A finished result waits in the output register, so the next beat is taken
// while the sink stalls; only a second result blocks until the first leaves.
module tone_envelope_synth_voice_core
  import tesv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tesv_in_if.sink               in_i,
  tesv_out_if.source            out_o
);

  // common width for note length / index compares
  localparam int unsigned N_W   = INDEX_BITS + 1;
  localparam int unsigned CMP_W = ((N_W > CNT_W) ? N_W : CNT_W) + 1;
  // phase step glide arithmetic
  localparam int unsigned SUM_W = ((PHASE_BITS > GLIDE_W) ? PHASE_BITS : GLIDE_W) + 2;
  localparam int unsigned SCL_W = PROD_W + AMP_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_WAVE, S_DIV, S_MUL1, S_MUL2, S_SCALE, S_DONE
  } state_e;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [WAVE_W-1:0]  waveform_q;
  logic [INC_W-1:0]   start_inc_q;
  logic [GLIDE_W-1:0] glide_q;
  logic [CNT_W-1:0]   total_q;
  logic [CNT_W-1:0]   attack_q;
  logic [CNT_W-1:0]   decay_q;
  logic [VOL_W-1:0]   volume_q;
  logic [SEED_W-1:0]  seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q  <= '0;
      start_inc_q <= '0;
      glide_q     <= '0;
      total_q     <= CNT_W'(1);
      attack_q    <= '0;
      decay_q     <= '0;
      volume_q    <= VOL_RESET;
      seed_q      <= SEED_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WAVEFORM:   waveform_q  <= cfg_data_i[WAVE_W-1:0];
        CFG_START_INC:  start_inc_q <= cfg_data_i[INC_W-1:0];
        CFG_GLIDE:      glide_q     <= cfg_data_i[GLIDE_W-1:0];
        CFG_TOTAL:      total_q     <= cfg_data_i[CNT_W-1:0];
        CFG_ATTACK:     attack_q    <= cfg_data_i[CNT_W-1:0];
        CFG_DECAY:      decay_q     <= cfg_data_i[CNT_W-1:0];
        CFG_VOLUME:     volume_q    <= cfg_data_i[VOL_W-1:0];
        CFG_NOISE_SEED: seed_q      <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // voice state and datapath registers
  // ---------------------------------------------------------------------
  state_e                  state_q;
  logic                    note_on_q;
  logic [INDEX_BITS-1:0]   idx_q;
  logic [PHASE_BITS-1:0]   phase_q;
  logic [PHASE_BITS-1:0]   step_q;
  logic [SEED_W-1:0]       lfsr_q;
  logic                    last_q;
  logic                    use_div_q;
  logic                    neg_q;
  logic [MAG_W-1:0]        mag_q;
  logic [ENV_W-1:0]        env_q;
  logic [PROD_W-1:0]       prod_q;
  logic signed [MAG_W-1:0] rom_q;
  logic signed [SAMPLE_W-1:0] res_sample_q;
  logic                    res_active_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;
  logic                       out_active_q;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // sine table read, registered; address from the phase in S_PREP
  always_ff @(posedge clk_i) begin
    rom_q <= SINE_ROM[phase_q[PHASE_BITS-1 -: SINE_ABITS]];
  end

  // ---------------------------------------------------------------------
  // note length, last flag and envelope ramp select (S_PREP)
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] n_len;
  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] att_x;
  logic [CMP_W-1:0] dec_x;
  logic [CMP_W-1:0] left_x;
  logic             is_last;
  logic             in_attack;
  logic             in_decay;
  div_req_t         div_req;
  div_resp_t        div_resp;

  always_comb begin
    n_len = CMP_W'(total_q);
    if (total_q == '0) n_len = CMP_W'(1);
    if (n_len > (CMP_W'(1) << INDEX_BITS)) n_len = CMP_W'(1) << INDEX_BITS;
    idx_x = CMP_W'(idx_q);
    att_x = CMP_W'(attack_q);
    dec_x = CMP_W'(decay_q);
    is_last   = (idx_x + CMP_W'(1) >= n_len);
    in_attack = (attack_q != '0) && (idx_x < att_x);
    in_decay  = (decay_q != '0) && (idx_x + dec_x > n_len);
    left_x    = (idx_x < n_len) ? (n_len - idx_x) : '0;

    div_req.start    = (state_q == S_PREP) && note_on_q && (in_attack || in_decay);
    div_req.dividend = in_attack ? idx_x[CNT_W-1:0] : left_x[CNT_W-1:0];
    div_req.divisor  = in_attack ? attack_q : decay_q;
  end

  tesv_env_div u_env_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  // ---------------------------------------------------------------------
  // waveform (S_WAVE): signed Q1.15 value, split into sign and magnitude
  // ---------------------------------------------------------------------
  logic [15:0]        u_frac;
  logic signed [17:0] wave;
  logic [17:0]        wave_abs;

  always_comb begin
    u_frac = phase_q[PHASE_BITS-1 -: 16];
    case (wave_e'(waveform_q))
      WAVE_SINE:     wave = 18'(rom_q);
      WAVE_SQUARE:   wave = u_frac[15] ? -18'sd32768 : 18'sd32768;
      WAVE_TRIANGLE: wave = u_frac[15] ? (18'sd98304 - signed'({1'b0, u_frac, 1'b0}))
                                       : (signed'({1'b0, u_frac, 1'b0}) - 18'sd32768);
      WAVE_SAW:      wave = signed'({2'b00, u_frac}) - 18'sd32768;
      WAVE_NOISE:    wave = signed'({2'b00, lfsr_q[SEED_W-1 -: 16]}) - 18'sd32768;
      default:       wave = '0;
    endcase
    wave_abs = wave[17] ? 18'(-wave) : 18'(wave);
  end

  // ---------------------------------------------------------------------
  // phase step glide with saturation to [0, 2^(PHASE_BITS-1)]
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] step_top;
  logic signed [SUM_W-1:0] step_sum;
  logic [PHASE_BITS-1:0]   step_glided;
  logic [PHASE_BITS-1:0]   step_loaded;
  logic [SEED_W-1:0]       lfsr_next;

  always_comb begin
    step_top = SUM_W'(1) << (PHASE_BITS - 1);
    step_sum = signed'(SUM_W'(step_q)) +
               signed'({{(SUM_W-GLIDE_W){glide_q[GLIDE_W-1]}}, glide_q});
    if (step_sum < 0) step_glided = '0;
    else if (step_sum > step_top) step_glided = step_top[PHASE_BITS-1:0];
    else step_glided = step_sum[PHASE_BITS-1:0];

    if (signed'(SUM_W'(start_inc_q)) > step_top) step_loaded = step_top[PHASE_BITS-1:0];
    else step_loaded = PHASE_BITS'(start_inc_q);

    // Galois step
    lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
  end

  // ---------------------------------------------------------------------
  // shared multiplier: volume*env, then that product times |wave|
  // ---------------------------------------------------------------------
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [SCL_W-1:0]   scaled;
  logic [MAG_W-1:0]   out_mag;
  logic signed [SAMPLE_W-1:0] sat_sample;

  always_comb begin
    mul_a = MUL_A_W'(volume_q);
    mul_b = MUL_B_W'(env_q);
    if (state_q == S_MUL2) begin
      mul_a = prod_q[MUL_A_W-1:0];
      mul_b = mag_q;
    end
  end

  assign mul_p = mul_a * mul_b;

  // times 32767 as shift and subtract, then drop 47 fraction bits
  always_comb begin
    scaled  = {prod_q, {AMP_SHIFT{1'b0}}} - SCL_W'(prod_q);
    out_mag = scaled[OUT_SHIFT +: MAG_W];
    if (neg_q) begin
      if (out_mag > MAG_W'(32768)) sat_sample = -16'sd32768;
      else sat_sample = SAMPLE_W'(-out_mag);
    end else begin
      if (out_mag > MAG_W'(32767)) sat_sample = 16'sd32767;
      else sat_sample = out_mag[SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  logic in_fire;
  logic out_free;
  logic out_load;

  assign in_fire  = in_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      note_on_q    <= 1'b0;
      idx_q        <= '0;
      phase_q      <= '0;
      step_q       <= '0;
      lfsr_q       <= SEED_DEFAULT;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_last_q   <= 1'b0;
      out_active_q <= 1'b0;
      last_q       <= 1'b0;
      use_div_q    <= 1'b0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      env_q        <= '0;
      prod_q       <= '0;
      res_sample_q <= '0;
      res_active_q <= 1'b0;
    end else begin
      // output register: loaded from S_DONE, emptied when the sink takes it
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.start_req) begin
              note_on_q <= 1'b1;
              idx_q     <= '0;
              phase_q   <= '0;
              step_q    <= step_loaded;
              lfsr_q    <= (seed_q != '0) ? seed_q : SEED_DEFAULT;
            end
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (!note_on_q) begin
            // idle voice: all-zero beat
            res_sample_q <= '0;
            last_q       <= 1'b0;
            res_active_q <= 1'b0;
            state_q      <= S_DONE;
          end else begin
            last_q       <= is_last;
            res_active_q <= 1'b1;
            use_div_q    <= in_attack || in_decay;
            env_q        <= ENV_W'(1) << ENV_FRAC;
            lfsr_q       <= lfsr_next;
            state_q      <= S_WAVE;
          end
        end
        S_WAVE: begin
          neg_q   <= wave[17];
          mag_q   <= wave_abs[MAG_W-1:0];
          phase_q <= phase_q + step_q;
          step_q  <= step_glided;
          if (last_q) note_on_q <= 1'b0;
          else idx_q <= idx_q + 1'b1;
          state_q <= use_div_q ? S_DIV : S_MUL1;
        end
        S_DIV: begin
          if (div_resp.done) begin
            env_q   <= ENV_W'(div_resp.quotient);
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_q  <= mul_p;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          prod_q  <= mul_p;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          res_sample_q <= sat_sample;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_sample_q <= res_sample_q;
            out_last_q   <= last_q;
            out_active_q <= res_active_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.sample = out_sample_q;
  assign out_o.last   = out_last_q;
  assign out_o.active = out_active_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
`include "assert_macros.svh"

  `TESV_ASSERT(a_no_accept_while_div, (in_i.valid && in_i.ready) |-> !div_resp.busy, "beat taken while divider busy")
  `TESV_ASSERT(a_idle_beat_zero, (out_o.valid && !out_o.active) |-> (out_o.sample == '0 && !out_o.last), "idle beat not zero")
  `TESV_ASSERT_NEVER(a_step_bound, step_q > (PHASE_BITS'(1) << (PHASE_BITS - 1)), "phase step out of range")
  `TESV_ASSERT(a_mul_after_div, (state_q == S_MUL1 && $past(state_q) == S_DIV) |-> $past(div_resp.done), "envelope taken before divide done")

endmodule

### rtl/core/tesv_env_div.sv
// Serial restoring divider for the envelope ramp: floor(x * 2^16 / d), x < d.
// One quotient bit per cycle. Uses tesv_pkg.
module tesv_env_div
  import tesv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_req_t  req_i,
  output div_resp_t resp_o
);

  localparam int unsigned CNTR_W = $clog2(ENV_FRAC + 1);

  logic [CNT_W-1:0]    rem_q;
  logic [CNT_W-1:0]    den_q;
  logic [ENV_FRAC-1:0] quo_q;
  logic [CNTR_W-1:0]   cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [CNT_W:0] rem2;
  logic [CNT_W:0] diff;
  logic           fits;

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign fits = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      rem_q  <= req_i.dividend;
      den_q  <= req_i.divisor;
      quo_q  <= '0;
      cnt_q  <= CNTR_W'(ENV_FRAC);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[CNT_W-1:0] : rem2[CNT_W-1:0];
      quo_q <= {quo_q[ENV_FRAC-2:0], fits};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTR_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign resp_o.busy     = busy_q;
  assign resp_o.done     = done_q;
  assign resp_o.quotient = quo_q;

endmodule

### test/testbench.sv
// Self-checking bench for tone_envelope_synth_voice_core: directed notes, then random phases.
// Needs tesv_pkg, tesv_in_if / tesv_out_if and the voice core RTL.
`timescale 1ns / 1ps

module testbench;
  import tesv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_TICKS = 650;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       active;
  } pcm_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tesv_in_if  tick_if ();
  tesv_out_if pcm_if ();

  tone_envelope_synth_voice_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_if),
    .out_o      (pcm_if)
  );

  // register copies, as the voice sees them
  logic [WAVE_W-1:0]  voice_wave;
  logic [INC_W-1:0]   voice_inc;
  logic [GLIDE_W-1:0] voice_glide;
  logic [CNT_W-1:0]   voice_total;
  logic [CNT_W-1:0]   voice_attack;
  logic [CNT_W-1:0]   voice_decay;
  logic [VOL_W-1:0]   voice_vol;
  logic [SEED_W-1:0]  voice_seed;

  // voice state
  logic [INDEX_BITS-1:0] note_pos;
  logic [PHASE_BITS-1:0] phase;
  logic [GLIDE_W-1:0]    step;
  logic [SEED_W-1:0]     lfsr;
  logic                  sounding;

  int        sine_q15 [SINE_DEPTH];
  logic      tick_queue [$];
  pcm_beat_t pcm_expected [$];
  pcm_beat_t want;
  int        mismatches;
  int        cycles;
  logic      calm;  // no idling on either side

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // round(32768*sin(pi/2 * r/depth)) by a Taylor series up to x^13 in Q30
  function automatic longint quarter_tone(longint r);
    longint x;
    longint term;
    longint sum;
    longint v;
    x = (64'd1686629713 * r) / SINE_DEPTH;
    term = x;
    sum = x;
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum * 32768 + 64'sd536870912) >>> 30;
    if (v > 32768) v = 32768;
    return v;
  endfunction

  function automatic logic [GLIDE_W-1:0] clip_step(longint s);
    if (s < 0) return '0;
    if (s > (64'sd1 <<< (PHASE_BITS - 1))) return GLIDE_W'(1) << (PHASE_BITS - 1);
    return GLIDE_W'(s);
  endfunction

  // One sample tick of the voice: returns the beat it must produce.
  function automatic pcm_beat_t voice_tick(logic start);
    pcm_beat_t       o;
    longint unsigned len;
    longint unsigned pos;
    longint unsigned env;
    longint unsigned mag;
    longint unsigned left;
    longint          glide;
    int              u;
    int              w;
    int              s;
    logic            fin;
    o = '0;
    if (start) begin
      sounding = 1'b1;
      note_pos = '0;
      phase = '0;
      step = clip_step(longint'(voice_inc));
      lfsr = (voice_seed != 0) ? voice_seed : SEED_DEFAULT;
    end
    if (!sounding) return o;

    len = voice_total;
    if (len == 0) len = 1;
    if (len > (64'd1 << INDEX_BITS)) len = 64'd1 << INDEX_BITS;
    pos = note_pos;
    fin = (pos + 1 >= len);

    // noise advances on every sounding tick, before it is read
    lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
    u = int'(phase[PHASE_BITS-1 -: 16]);
    case (voice_wave)
      WAVE_SINE:     w = sine_q15[phase[PHASE_BITS-1 -: SINE_ABITS]];
      WAVE_SQUARE:   w = (u < 32768) ? 32768 : -32768;
      WAVE_TRIANGLE: w = (u < 32768) ? (2 * u - 32768) : (98304 - 2 * u);
      WAVE_SAW:      w = u - 32768;
      WAVE_NOISE:    w = int'(lfsr[31:16]) - 32768;
      default:       w = 0;
    endcase

    // attack ramp wins over decay ramp; a zero-length ramp never applies
    if (voice_attack != 0 && pos < voice_attack) begin
      env = (pos << 16) / voice_attack;
    end else if (voice_decay != 0 && pos + voice_decay > len) begin
      left = (pos < len) ? len - pos : 0;
      env = (left << 16) / voice_decay;
      if (env > 65536) env = 65536;
    end else begin
      env = 65536;
    end

    mag = w < 0 ? longint'(-w) : longint'(w);
    mag = (64'd32767 * voice_vol * env * mag) >> OUT_SHIFT;
    if (w < 0) s = (mag > 32768) ? -32768 : -int'(mag);
    else s = (mag > 32767) ? 32767 : int'(mag);

    o.sample = s[SAMPLE_W-1:0];
    o.last = fin;
    o.active = 1'b1;

    glide = longint'(signed'(voice_glide));
    phase = phase + step[PHASE_BITS-1:0];
    step = clip_step(longint'(step) + glide);
    if (fin) sounding = 1'b0;
    else note_pos = note_pos + 1'b1;
    return o;
  endfunction

  // Driver: holds a beat until taken, idles at random between beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      tick_if.start_req <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        pcm_expected.push_back(voice_tick(tick_if.start_req));
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
          tick_if.valid <= 1'b1;
          tick_if.start_req <= tick_queue.pop_front();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, each PCM beat checked against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcm_if.ready <= 1'b0;
    end else begin
      pcm_if.ready <= calm || ($urandom_range(99) >= 19);
      if (pcm_if.valid && pcm_if.ready) begin
        if (pcm_expected.size() == 0) begin
          mismatches++;
          $error("unexpected beat: sample %0d last %0b active %0b",
                 pcm_if.sample, pcm_if.last, pcm_if.active);
        end else begin
          want = pcm_expected.pop_front();
          if (pcm_if.sample !== want.sample) begin
            mismatches++;
            $error("sample: expected %0d, got %0d", want.sample, pcm_if.sample);
          end
          if (pcm_if.last !== want.last) begin
            mismatches++;
            $error("last: expected %0b, got %0b", want.last, pcm_if.last);
          end
          if (pcm_if.active !== want.active) begin
            mismatches++;
            $error("active: expected %0b, got %0b", want.active, pcm_if.active);
          end
        end
      end
    end
  end

  // Register write at the next edge; the bench copy follows at once since
  // writes only happen with the voice idle.
  task automatic reg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_WAVEFORM:   voice_wave = val[WAVE_W-1:0];
      CFG_START_INC:  voice_inc = val[INC_W-1:0];
      CFG_GLIDE:      voice_glide = val[GLIDE_W-1:0];
      CFG_TOTAL:      voice_total = val[CNT_W-1:0];
      CFG_ATTACK:     voice_attack = val[CNT_W-1:0];
      CFG_DECAY:      voice_decay = val[CNT_W-1:0];
      CFG_VOLUME:     voice_vol = val[VOL_W-1:0];
      CFG_NOISE_SEED: voice_seed = val[SEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sender stops until every queued tick is taken and every PCM beat is back.
  task automatic settle();
    while (tick_queue.size() != 0 || tick_if.valid || pcm_expected.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned len;
    int unsigned sel;
    int          ph;
    logic [CFG_DATA_W-1:0] val;
    longint m;
    longint quad;
    longint rem;
    longint v;

    for (int k = 0; k < SINE_DEPTH; k++) begin
      m = 4 * k;
      quad = m / SINE_DEPTH;
      rem = m % SINE_DEPTH;
      v = quarter_tone((quad % 2 == 1) ? SINE_DEPTH - rem : rem);
      sine_q15[k] = (quad >= 2) ? -int'(v) : int'(v);
    end

    voice_wave = WAVE_SINE;
    voice_inc = '0;
    voice_glide = '0;
    voice_total = CNT_W'(1);
    voice_attack = '0;
    voice_decay = '0;
    voice_vol = VOL_RESET;
    voice_seed = SEED_DEFAULT;
    note_pos = '0;
    phase = '0;
    step = '0;
    lfsr = SEED_DEFAULT;
    sounding = 1'b0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    tick_if.valid = 1'b0;
    tick_if.start_req = 1'b0;
    pcm_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: idle voice gives zeros, one-sample sine note at phase 0
    tick_queue = '{1'b0, 1'b1, 1'b0};
    settle();

    // sine stepping a quarter cycle per tick, short attack and decay ramps
    reg_write(CFG_WAVEFORM, WAVE_SINE);
    reg_write(CFG_START_INC, 32'h40_0000);
    reg_write(CFG_TOTAL, 32'd6);
    reg_write(CFG_ATTACK, 32'd2);
    reg_write(CFG_DECAY, 32'd2);
    reg_done();
    tick_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    settle();

    // square over full scale volume; start step clamps high, glide clamps it to zero
    reg_write(CFG_WAVEFORM, WAVE_SQUARE);
    reg_write(CFG_START_INC, 32'hFF_FFFF);
    reg_write(CFG_GLIDE, 32'h100_0000);
    reg_write(CFG_TOTAL, 32'd100);
    reg_write(CFG_ATTACK, 32'd0);
    reg_write(CFG_DECAY, 32'd0);
    reg_write(CFG_VOLUME, 32'h1_FFFF);
    reg_done();
    tick_queue = '{1'b1, 1'b0, 1'b0};
    settle();

    // note shortened while it sounds: the next tick is its last
    reg_write(CFG_WAVEFORM, WAVE_TRIANGLE);
    reg_write(CFG_TOTAL, 32'd2);
    reg_done();
    tick_queue = '{1'b0, 1'b0};
    settle();

    // noise from a zero seed, longest note, top glide, huge ramps
    reg_write(CFG_WAVEFORM, WAVE_NOISE);
    reg_write(CFG_NOISE_SEED, 32'd0);
    reg_write(CFG_TOTAL, 32'h1F_FFFF);
    reg_write(CFG_START_INC, 32'd0);
    reg_write(CFG_GLIDE, 32'hFF_FFFF);
    reg_write(CFG_ATTACK, 32'h10_0000);
    reg_write(CFG_DECAY, 32'h10_0000);
    reg_write(CFG_VOLUME, 32'h1_0000);
    reg_done();
    tick_queue = '{1'b1, 1'b0, 1'b0};
    settle();

    // unused waveform code gives silence while the note runs on
    reg_write(CFG_WAVEFORM, 32'd7);
    reg_done();
    tick_queue = '{1'b0};
    settle();

    // sawtooth, note cut to one sample, then a fresh one-sample note
    reg_write(CFG_WAVEFORM, WAVE_SAW);
    reg_write(CFG_ATTACK, 32'd0);
    reg_write(CFG_DECAY, 32'd0);
    reg_write(CFG_TOTAL, 32'd1);
    reg_write(CFG_NOISE_SEED, 32'hFFFF_FFFF);
    reg_done();
    tick_queue = '{1'b0, 1'b1};
    settle();

    // random phases: new settings each time, then a run of ticks with sparse restarts
    sent = 0;
    for (ph = 0; sent < RANDOM_TICKS; ph++) begin
      calm = (ph >= 4 && ph < 8);
      for (int r = 0; r < 8; r++) begin
        if (ph == 0 || $urandom_range(1) == 1) begin
          sel = $urandom_range(7);
          case (cfg_idx_e'(r))
            CFG_WAVEFORM: begin
              v = $urandom_range(11);
              val = (v < 10) ? 32'(v % 5) : 32'($urandom_range(5, 7));
            end
            CFG_START_INC: begin
              case (sel)
                0: val = 32'h80_0000;
                1: val = 32'hFF_FFFF;
                2, 3: val = $urandom_range(1 << 16);
                default: val = $urandom() & 32'hFF_FFFF;
              endcase
            end
            CFG_GLIDE: begin
              case (sel)
                0: val = 32'h100_0000;
                1: val = 32'h80_0000;
                2: val = $urandom() & 32'h1FF_FFFF;
                3, 4: val = 32'(-$urandom_range(2000) + 1000) & 32'h1FF_FFFF;
                default: val = 32'd0;
              endcase
            end
            CFG_TOTAL: begin
              case (sel)
                0: val = 32'd0;
                1: val = ($urandom_range(1) == 1) ? 32'h10_0000 : 32'h1F_FFFF;
                default: val = $urandom_range(1, 40);
              endcase
            end
            CFG_ATTACK, CFG_DECAY: begin
              case (sel)
                0, 1: val = 32'd0;
                2: val = $urandom() & 32'h1F_FFFF;
                default: val = $urandom_range(1, 24);
              endcase
            end
            CFG_VOLUME: begin
              case (sel)
                0: val = 32'd0;
                1, 2: val = 32'h1_0000;
                3: val = $urandom() & 32'h1_FFFF;
                default: val = $urandom_range(1 << 16);
              endcase
            end
            default: val = (sel == 0) ? 32'd0 : $urandom();
          endcase
          reg_write(cfg_idx_e'(r), val);
        end
      end
      reg_done();
      len = $urandom_range(20, 60);
      for (int j = 0; j < len; j++)
        tick_queue.push_back((j == 0 && $urandom_range(3) != 0) || $urandom_range(15) == 0);
      sent += len;
      settle();
    end

    calm = 1'b0;
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && pcm_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tesv_pkg.sv
rtl/core/tesv_if.sv
rtl/core/tesv_env_div.sv
rtl/core/tone_envelope_synth_voice_core.sv
test/testbench.sv
